// File: rtl/ifrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrf_pkg
// Types and constants shared by the interleaved frame ring fifo blocks.
// ----------------------------------------------------------------------------
package ifrf_pkg;

	localparam int SMP_W    = 32;
	localparam int NUM_SMP  = 8;
	localparam int CH_W     = 4;
	localparam int CAP_W    = 10;
	localparam int FILL_W   = 10;
	localparam int EPOCH_W  = 32;
	localparam int COUNT_W  = 32;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int CH_RESET  = 2;
	localparam int CAP_RESET = 1023;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [STATUS_W-1:0] STS_DONE    = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FLUSHED = 3'd3;
	localparam logic [STATUS_W-1:0] STS_OTHER   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [SMP_W-1:0] sample_0;
		logic [SMP_W-1:0] sample_1;
		logic [SMP_W-1:0] sample_2;
		logic [SMP_W-1:0] sample_3;
		logic [SMP_W-1:0] sample_4;
		logic [SMP_W-1:0] sample_5;
		logic [SMP_W-1:0] sample_6;
		logic [SMP_W-1:0] sample_7;
		logic             last;
		logic [EPOCH_W-1:0] query_epoch;
	} in_item_t;

	typedef struct packed {
		logic [SMP_W-1:0]    out_0;
		logic [SMP_W-1:0]    out_1;
		logic [SMP_W-1:0]    out_2;
		logic [SMP_W-1:0]    out_3;
		logic [SMP_W-1:0]    out_4;
		logic [SMP_W-1:0]    out_5;
		logic [SMP_W-1:0]    out_6;
		logic [SMP_W-1:0]    out_7;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [FILL_W-1:0]   fill_frames;
		logic                reset_done;
	} out_item_t;

	typedef struct packed {
		logic execute;
		logic respond;
	} ctrl_cmd_t;

endpackage

// File: rtl/ifrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrf_ctrl
// Handshake controller: takes one word, then holds its result until taken.
// ----------------------------------------------------------------------------
module ifrf_ctrl import ifrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.execute = 1'b0;
		cmd.respond = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.execute = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_RESP: begin
				out_valid   = 1'b1;
				cmd.respond = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/ifrf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrf_datapath
// Frame store, ring pointers, epochs, call tracking and result registers.
// ----------------------------------------------------------------------------
module ifrf_datapath import ifrf_pkg::*; #(
	parameter int RING_SLOTS   = 1024,
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output out_item_t             out_data
);

	localparam int PW = $clog2(RING_SLOTS);
	localparam int CW = (PW > CAP_W) ? PW : CAP_W;
	localparam int WW = MAX_CHANNELS * SAMPLE_BITS;

	function automatic logic [PW-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [CW-1:0] e;
		logic [CW-1:0] lim;
		e   = CW'(v);
		lim = CW'(RING_SLOTS - 1);
		if (e < CW'(2)) begin
			e = CW'(2);
		end else if (e > lim) begin
			e = lim;
		end
		return e[PW-1:0];
	endfunction

	function automatic logic [MAX_CHANNELS-1:0] ch_mask(input logic [CH_W-1:0] v);
		logic [CH_W-1:0]         n;
		logic [MAX_CHANNELS-1:0] m;
		n = v;
		if (n == '0) begin
			n = CH_W'(1);
		end else if (n > CH_W'(MAX_CHANNELS)) begin
			n = CH_W'(MAX_CHANNELS);
		end
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			m[i] = (CH_W'(i) < n);
		end
		return m;
	endfunction

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p,
			input logic [PW-1:0] cap);
		return (p == cap) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w,
			input logic [PW-1:0] r, input logic [PW-1:0] cap);
		return (w >= r) ? (w - r) : (w - r + cap + PW'(1));
	endfunction

	localparam logic [PW-1:0]           CAP_RST = clamp_cap(CAP_W'(CAP_RESET));
	localparam logic [MAX_CHANNELS-1:0] CH_RST  = ch_mask(CH_W'(CH_RESET));

	// frame store
	logic [WW-1:0] mem [RING_SLOTS];
	logic [WW-1:0] rdata_q;

	// state
	logic [PW-1:0]           rp_q, wp_q;
	logic [EPOCH_W-1:0]      req_q, ack_q;
	logic                    in_call_q, flushed_q, call_rd_q;
	logic [COUNT_W-1:0]      frames_q;
	logic [PW-1:0]           cap_q;
	logic [MAX_CHANNELS-1:0] chm_q;

	// result registers
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PW-1:0]       fill_q;
	logic                done_q;
	logic                hit_q;

	// next values
	logic [PW-1:0]       rp_n, wp_n, fill_cur, fill_n;
	logic [EPOCH_W-1:0]  req_n, ack_n;
	logic                in_call_n, flushed_n, call_rd_n;
	logic [COUNT_W-1:0]  frames_n, count_n;
	logic [STATUS_W-1:0] status_n;
	logic                done_n, hit_n, mem_we, mem_re;
	logic                is_wr, is_rd, first;
	logic [WW-1:0]       wdata;
	logic [SMP_W-1:0]    smp [NUM_SMP];

	assign smp[0] = in_data.sample_0;
	assign smp[1] = in_data.sample_1;
	assign smp[2] = in_data.sample_2;
	assign smp[3] = in_data.sample_3;
	assign smp[4] = in_data.sample_4;
	assign smp[5] = in_data.sample_5;
	assign smp[6] = in_data.sample_6;
	assign smp[7] = in_data.sample_7;

	always_comb begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			wdata[i*SAMPLE_BITS +: SAMPLE_BITS] = chm_q[i] ? smp[i][SAMPLE_BITS-1:0] : '0;
		end
	end

	always_comb begin
		is_wr     = (in_data.cmd == CMD_WRITE);
		is_rd     = (in_data.cmd == CMD_READ);
		first     = !in_call_q || (call_rd_q != is_rd);
		fill_cur  = fill_of(wp_q, rp_q, cap_q);
		rp_n      = rp_q;
		wp_n      = wp_q;
		req_n     = req_q;
		ack_n     = ack_q;
		in_call_n = in_call_q;
		flushed_n = first ? 1'b0 : flushed_q;
		call_rd_n = call_rd_q;
		frames_n  = first ? '0 : frames_q;
		status_n  = STS_DONE;
		count_n   = '0;
		done_n    = 1'b0;
		hit_n     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (in_data.cmd)
			CMD_WRITE: begin
				if (fill_cur >= cap_q) begin
					status_n = STS_DROPPED;
				end else begin
					mem_we = 1'b1;
					wp_n   = next_ptr(wp_q, cap_q);
					if (frames_n != '1) begin
						frames_n = frames_n + COUNT_W'(1);
					end
				end
				count_n = frames_n;
			end
			CMD_READ: begin
				if (first && (req_q != ack_q)) begin
					rp_n      = wp_q;
					ack_n     = req_q;
					flushed_n = 1'b1;
				end
				if (flushed_n) begin
					status_n = STS_FLUSHED;
				end else if (fill_cur == '0) begin
					status_n = STS_EMPTY;
					count_n  = frames_n;
				end else begin
					mem_re = 1'b1;
					hit_n  = 1'b1;
					rp_n   = next_ptr(rp_q, cap_q);
					if (frames_n != '1) begin
						frames_n = frames_n + COUNT_W'(1);
					end
					count_n = frames_n;
				end
			end
			CMD_RESET: begin
				req_n   = req_q + EPOCH_W'(1);
				count_n = req_n;
			end
			CMD_QUERY: begin
				done_n = (ack_q >= in_data.query_epoch);
			end
			default: begin
				status_n = STS_OTHER;
			end
		endcase
		if (is_wr || is_rd) begin
			call_rd_n = is_rd;
			in_call_n = !in_data.last;
			if (in_data.last) begin
				flushed_n = 1'b0;
			end
		end else begin
			flushed_n = flushed_q;
			frames_n  = frames_q;
		end
		fill_n = fill_of(wp_n, rp_n, cap_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) begin
			mem[wp_q] <= wdata;
		end
		if (cmd.execute && mem_re) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			req_q     <= '0;
			ack_q     <= '0;
			in_call_q <= 1'b0;
			flushed_q <= 1'b0;
			call_rd_q <= 1'b0;
			frames_q  <= '0;
			cap_q     <= CAP_RST;
			chm_q     <= CH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNELS: begin
					chm_q <= ch_mask(cfg_data[CH_W-1:0]);
				end
				CFG_CAPACITY: begin
					cap_q <= clamp_cap(cfg_data[CAP_W-1:0]);
					rp_q  <= '0;
					wp_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.execute) begin
			rp_q      <= rp_n;
			wp_q      <= wp_n;
			req_q     <= req_n;
			ack_q     <= ack_n;
			in_call_q <= in_call_n;
			flushed_q <= flushed_n;
			call_rd_q <= call_rd_n;
			frames_q  <= frames_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= status_n;
			count_q  <= count_n;
			fill_q   <= fill_n;
			done_q   <= done_n;
			hit_q    <= hit_n;
		end
	end

	// output word
	logic [SMP_W-1:0] outs [NUM_SMP];
	logic [CW-1:0]    fill_ext;

	for (genvar g = 0; g < NUM_SMP; g++) begin : g_out
		if (g < MAX_CHANNELS) begin : g_act
			assign outs[g] = (cmd.respond && hit_q && chm_q[g]) ?
				SMP_W'(rdata_q[g*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
		end else begin : g_off
			assign outs[g] = '0;
		end
	end

	assign fill_ext = CW'(fill_q);

	assign out_data.out_0       = outs[0];
	assign out_data.out_1       = outs[1];
	assign out_data.out_2       = outs[2];
	assign out_data.out_3       = outs[3];
	assign out_data.out_4       = outs[4];
	assign out_data.out_5       = outs[5];
	assign out_data.out_6       = outs[6];
	assign out_data.out_7       = outs[7];
	assign out_data.status      = status_q;
	assign out_data.count       = count_q;
	assign out_data.fill_frames = fill_ext[FILL_W-1:0];
	assign out_data.reset_done  = done_q;

endmodule

// File: rtl/interleaved_frame_ring_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_frame_ring_fifo_core
// Multichannel frame ring fifo with epoch-based flush and status queries.
// ----------------------------------------------------------------------------
// the result is valid in the cycle after a word is accepted
// the controller takes a word only when it is idle
// one word in flight; input is taken again once the result is taken
// reset: pointers, epochs, call state and config return to defaults at once,
// frame store contents are left as they are
module interleaved_frame_ring_fifo_core import ifrf_pkg::*; #(
	parameter int RING_SLOTS   = 1024,
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ifrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ifrf_datapath #(
		.RING_SLOTS   (RING_SLOTS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

// File: rtl/ifrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrf_checker
// Port-level checks for the frame ring fifo, bound to the top level.
// ----------------------------------------------------------------------------
module ifrf_checker import ifrf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input out_item_t             out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result the cycle after accept");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STS_FLUSHED |-> out_data.count == '0)
		else $error("flushed read with nonzero count");

	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STS_DONE |->
			out_data.out_0 == '0 && out_data.out_1 == '0 && out_data.reset_done == 1'b0)
		else $error("samples on a result without data");

endmodule

bind interleaved_frame_ring_fifo_core ifrf_checker u_ifrf_checker (.*);
